FILE: src/mntdf_pkg.sv
// Shared types, constants and pitch code table for the MIDI note to DAC frame block.
`default_nettype none
package mntdf_pkg;

  localparam int unsigned NOTE_COUNT = 61;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] DAC_ADDR_RESET = 8'h20;
  localparam logic [7:0] STATUS_LOW     = 8'h80;
  localparam logic [7:0] SYSTEM_LOW     = 8'hF0;
  localparam logic [3:0] NOTE_ON_NIBBLE = 4'h9;
  localparam logic [3:0] CMD_WRITE_LOAD = 4'hB;
  localparam logic [7:0] LOW_BYTE_MASK  = 8'hF0;

  typedef enum logic [1:0] {
    PH_STATUS = 2'd0,
    PH_NOTE   = 2'd1,
    PH_VEL    = 2'd2,
    PH_SPARE  = 2'd3
  } parse_phase_e;

  typedef enum logic [1:0] {
    SLOT_ADDR  = 2'd0,
    SLOT_CMD   = 2'd1,
    SLOT_HIGH  = 2'd2,
    SLOT_LOW   = 2'd3
  } frame_slot_e;

  typedef struct packed {
    logic [3:0] channel;
    logic [6:0] note;
  } note_cmd_t;

  function automatic logic [15:0] pitch_code(input logic [6:0] idx);
    logic [15:0] code;
    unique case (idx)
      7'd0:  code = 16'h0000;  7'd1:  code = 16'h0440;  7'd2:  code = 16'h0880;
      7'd3:  code = 16'h0CD0;  7'd4:  code = 16'h1110;  7'd5:  code = 16'h1550;
      7'd6:  code = 16'h19A0;  7'd7:  code = 16'h1DE0;  7'd8:  code = 16'h2220;
      7'd9:  code = 16'h2660;  7'd10: code = 16'h2AA0;  7'd11: code = 16'h2EF0;
      7'd12: code = 16'h3330;  7'd13: code = 16'h3770;  7'd14: code = 16'h3BC0;
      7'd15: code = 16'h4000;  7'd16: code = 16'h4440;  7'd17: code = 16'h4880;
      7'd18: code = 16'h4CC0;  7'd19: code = 16'h5110;  7'd20: code = 16'h5550;
      7'd21: code = 16'h5990;  7'd22: code = 16'h5DE0;  7'd23: code = 16'h6220;
      7'd24: code = 16'h6660;  7'd25: code = 16'h6AA0;  7'd26: code = 16'h6EE0;
      7'd27: code = 16'h7330;  7'd28: code = 16'h7770;  7'd29: code = 16'h7BB0;
      7'd30: code = 16'h8000;  7'd31: code = 16'h8440;  7'd32: code = 16'h8880;
      7'd33: code = 16'h8CC0;  7'd34: code = 16'h9100;  7'd35: code = 16'h9550;
      7'd36: code = 16'h9990;  7'd37: code = 16'h9DD0;  7'd38: code = 16'hA220;
      7'd39: code = 16'hA660;  7'd40: code = 16'hAAA0;  7'd41: code = 16'hAEE0;
      7'd42: code = 16'hB320;  7'd43: code = 16'hB770;  7'd44: code = 16'hBBB0;
      7'd45: code = 16'hBFF0;  7'd46: code = 16'hC440;  7'd47: code = 16'hC880;
      7'd48: code = 16'hCCC0;  7'd49: code = 16'hD100;  7'd50: code = 16'hD550;
      7'd51: code = 16'hD990;  7'd52: code = 16'hDDD0;  7'd53: code = 16'hE210;
      7'd54: code = 16'hE660;  7'd55: code = 16'hEAA0;  7'd56: code = 16'hEEE0;
      7'd57: code = 16'hF320;  7'd58: code = 16'hF760;  7'd59: code = 16'hFBB0;
      default: code = 16'hFFF0;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

FILE: src/mntdf_if.sv
// Valid/ready channel interfaces for received MIDI bytes and DAC frame bytes.
`default_nettype none
interface midi_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface dac_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       frame_start;
  logic       frame_last;

  modport source (output valid, output tx_byte, output frame_start, output frame_last,
                  input ready);
  modport sink (input valid, input tx_byte, input frame_start, input frame_last,
                output ready);
endinterface
`default_nettype wire

FILE: src/midi_note_to_dac_frame.sv
// MIDI note-on to DAC write frame converter: top level.
//
// midi_rx takes one received MIDI byte per beat (valid/ready). The parser
// waits for a channel status byte, then takes two data bytes; a note-on with
// non-zero velocity and an in-range note queues one command.
// dac_tx gives four beats per command: device address (frame_start set),
// 0xB0 ORed with the channel, pitch code high byte, and pitch code low byte
// masked to its top nibble (frame_last set).
// The device address register is written with cfg_we_i/cfg_wdata_i; the user must do so
// only while the block is idle, which the block itself does not enforce; reset loads 0x20.
// The velocity beat pushes a command into the queue; the framer then loads the first frame beat from it.
// Throughput: one input beat per cycle while the two-entry command queue
// has room; the sender gives one output beat per cycle from the single
// output register while dac_tx is ready and a command is queued.
// When dac_tx stalls, the output register holds its beat, the queue fills,
// and midi_rx ready drops once both queue entries are taken.
// Reset clears the parser state, the queue pointers and count, and the output valid and slot.
`default_nettype none
module midi_note_to_dac_frame (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  midi_byte_if.sink       midi_rx,
  dac_frame_if.source     dac_tx
);

  logic [7:0]           dac_addr_q;
  logic                 q_push, q_pop, q_full, q_empty;
  mntdf_pkg::note_cmd_t push_cmd, head_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dac_addr_q <= mntdf_pkg::DAC_ADDR_RESET;
    end else if (cfg_we_i) begin
      dac_addr_q <= cfg_wdata_i;
    end
  end

  mntdf_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (midi_rx.valid),
    .rx_ready_o (midi_rx.ready),
    .rx_byte_i  (midi_rx.rx_byte),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  mntdf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .head_cmd_o (head_cmd),
    .empty_o    (q_empty)
  );

  mntdf_framer u_framer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dac_addr_i    (dac_addr_q),
    .cmd_i         (head_cmd),
    .cmd_empty_i   (q_empty),
    .cmd_pop_o     (q_pop),
    .tx_valid_o    (dac_tx.valid),
    .tx_ready_i    (dac_tx.ready),
    .tx_byte_o     (dac_tx.tx_byte),
    .frame_start_o (dac_tx.frame_start),
    .frame_last_o  (dac_tx.frame_last)
  );

endmodule
`default_nettype wire

FILE: src/mntdf_parser.sv
// Front end: MIDI message parser that queues note-on commands.
`default_nettype none
module mntdf_parser (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 rx_valid_i,
  output logic                      rx_ready_o,
  input  wire logic [7:0]           rx_byte_i,
  input  wire logic                 q_full_i,
  output logic                      q_push_o,
  output mntdf_pkg::note_cmd_t      q_cmd_o
);

  mntdf_pkg::parse_phase_e phase_q, phase_d;
  logic [7:0] status_q, status_d;
  logic [7:0] note_q, note_d;
  logic       beat;
  logic       is_note_on;

  assign rx_ready_o = !q_full_i;
  assign beat       = rx_valid_i && rx_ready_o;
  assign is_note_on = (status_q[7:4] == mntdf_pkg::NOTE_ON_NIBBLE) && (rx_byte_i != 8'd0)
                      && (note_q < 8'(mntdf_pkg::NOTE_COUNT));

  always_comb begin
    phase_d  = phase_q;
    status_d = status_q;
    note_d   = note_q;
    q_push_o = 1'b0;
    if (beat) begin
      unique case (phase_q)
        mntdf_pkg::PH_NOTE: begin
          note_d  = rx_byte_i;
          phase_d = mntdf_pkg::PH_VEL;
        end
        mntdf_pkg::PH_VEL: begin
          phase_d  = mntdf_pkg::PH_STATUS;
          q_push_o = is_note_on;
        end
        default: begin
          phase_d = mntdf_pkg::PH_STATUS;
          if (rx_byte_i >= mntdf_pkg::STATUS_LOW && rx_byte_i < mntdf_pkg::SYSTEM_LOW) begin
            status_d = rx_byte_i;
            phase_d  = mntdf_pkg::PH_NOTE;
          end
        end
      endcase
    end
  end

  assign q_cmd_o.channel = status_q[3:0];
  assign q_cmd_o.note    = note_q[6:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= mntdf_pkg::PH_STATUS;
      status_q <= 8'd0;
      note_q   <= 8'd0;
    end else begin
      phase_q  <= phase_d;
      status_q <= status_d;
      note_q   <= note_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/mntdf_queue.sv
// Short command queue between the parser and the frame sender.
`default_nettype none
module mntdf_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  mntdf_pkg::note_cmd_t      push_cmd_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output mntdf_pkg::note_cmd_t      head_cmd_o,
  output logic                      empty_o
);

  mntdf_pkg::note_cmd_t mem_q [mntdf_pkg::QUEUE_DEPTH];
  logic [mntdf_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [mntdf_pkg::QUEUE_CNT_W-1:0] count_q;

  assign full_o     = (count_q == mntdf_pkg::QUEUE_CNT_W'(mntdf_pkg::QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign head_cmd_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/mntdf_framer.sv
// Back end: serializes one queued note-on into a four-beat DAC write frame.
`default_nettype none
module mntdf_framer (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [7:0]           dac_addr_i,
  input  mntdf_pkg::note_cmd_t      cmd_i,
  input  wire logic                 cmd_empty_i,
  output logic                      cmd_pop_o,
  output logic                      tx_valid_o,
  input  wire logic                 tx_ready_i,
  output logic [7:0]                tx_byte_o,
  output logic                      frame_start_o,
  output logic                      frame_last_o
);

  mntdf_pkg::frame_slot_e slot_q;
  logic        valid_q;
  logic [7:0]  byte_q, byte_d;
  logic        start_q, last_q;
  logic        load;
  logic [15:0] code;

  assign code      = mntdf_pkg::pitch_code(cmd_i.note);
  assign load      = !cmd_empty_i && (!valid_q || tx_ready_i);
  assign cmd_pop_o = load && (slot_q == mntdf_pkg::SLOT_LOW);

  always_comb begin
    unique case (slot_q)
      mntdf_pkg::SLOT_ADDR: byte_d = dac_addr_i;
      mntdf_pkg::SLOT_CMD:  byte_d = {mntdf_pkg::CMD_WRITE_LOAD, cmd_i.channel};
      mntdf_pkg::SLOT_HIGH: byte_d = code[15:8];
      default:              byte_d = code[7:0] & mntdf_pkg::LOW_BYTE_MASK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= byte_d;
      start_q <= (slot_q == mntdf_pkg::SLOT_ADDR);
      last_q  <= (slot_q == mntdf_pkg::SLOT_LOW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      slot_q  <= mntdf_pkg::SLOT_ADDR;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        slot_q  <= mntdf_pkg::frame_slot_e'(slot_q + 2'd1);
      end else if (tx_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign tx_valid_o    = valid_q;
  assign tx_byte_o     = byte_q;
  assign frame_start_o = start_q;
  assign frame_last_o  = last_q;

endmodule
`default_nettype wire
